### rtl/core/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg
// Types and constants shared by the send rate limiter and its channels.
// ----------------------------------------------------------------------------
package srl_pkg;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 32;

	// register map of the configuration channel
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MIN_GAP       = 4'd0,
		REG_WINDOW_LENGTH = 4'd1,
		REG_BURST_LIMIT   = 4'd2,
		REG_PAYLOAD_LIMIT = 4'd3
	} reg_index_t;

	localparam logic [31:0] MIN_GAP_RST       = 32'd100;
	localparam logic [31:0] WINDOW_LENGTH_RST = 32'd1000;
	localparam logic [15:0] BURST_LIMIT_RST   = 16'd10;
	localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd4096;

	typedef struct packed {
		logic [31:0] time_now;
		logic [15:0] payload_size;
	} req_t;

	typedef struct packed {
		logic        send_ok;
		logic [31:0] drops_reported;
		logic [31:0] last_send_echo;
	} rsp_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_t;

endpackage

### rtl/core/srl_stream_if.sv
// ----------------------------------------------------------------------------
// srl_stream_if
// Valid/ready channel carrying one payload of type T per request.
// ----------------------------------------------------------------------------
interface srl_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/send_rate_limiter.sv
// ----------------------------------------------------------------------------
// send_rate_limiter
// Fixed-window burst limiter with a minimum gap between accepted sends.
// ----------------------------------------------------------------------------
// Takes one send request per clock and returns one decision per request: the
// request is captured in an input register, the gap, window and payload
// checks run as one subtract-and-compare against the registered limiter
// state, and the decision lands in the result register while the state
// updates in the same edge. A full result register that is not taken holds
// the input stage; otherwise a request enters every cycle.
// Times are taken modulo 2^TIME_BITS; a window start of zero means no window.
// Configuration writes are always accepted and should be made while idle.
module send_rate_limiter
	import srl_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	srl_stream_if.sink   req,
	srl_stream_if.source rsp,
	srl_stream_if.sink   cfg
);

	localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

	// configuration registers
	logic [31:0] min_gap_q;
	logic [31:0] window_length_q;
	logic [15:0] burst_limit_q;
	logic [15:0] payload_limit_q;

	// limiter state
	logic [TIME_BITS-1:0] prev_send_time_q;
	logic [TIME_BITS-1:0] window_begin_q;
	logic [15:0]          window_sends_q;
	logic                 any_sent_q;
	logic [31:0]          drop_tally_q;

	// input stage
	logic                 valid_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic [15:0]          size_s1;

	// result stage
	logic valid_s2;
	rsp_t rsp_s2;

	logic                 advance;
	logic                 ok;
	logic                 fresh;
	logic                 gap_short;
	logic [TIME_BITS-1:0] gap_diff;
	logic [TIME_BITS-1:0] win_diff;
	logic [31:0]          drop_next;
	logic [31:0]          cfg_val32;
	logic [15:0]          cfg_val16;

	assign cfg.ready = 1'b1;
	assign cfg_val32 = cfg.data.data;
	assign cfg_val16 = cfg.data.data[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q       <= MIN_GAP_RST;
			window_length_q <= WINDOW_LENGTH_RST;
			burst_limit_q   <= BURST_LIMIT_RST;
			payload_limit_q <= PAYLOAD_LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_MIN_GAP: begin
					min_gap_q <= (cfg_val32 == '0) ? 32'd1 : cfg_val32;
				end
				REG_WINDOW_LENGTH: begin
					window_length_q <= (cfg_val32 == '0) ? 32'd1 : cfg_val32;
				end
				REG_BURST_LIMIT: begin
					burst_limit_q <= (cfg_val16 == '0) ? 16'd1 : cfg_val16;
				end
				REG_PAYLOAD_LIMIT: begin
					payload_limit_q <= cfg_val16;
				end
				default: begin
				end
			endcase
		end
	end

	// the input stage moves on when the result register is free or being taken
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			time_s1 <= TIME_BITS'(req.data.time_now);
			size_s1 <= req.data.payload_size;
		end
	end

	// decision against the registered state
	always_comb begin
		gap_diff  = time_s1 - prev_send_time_q;
		win_diff  = time_s1 - window_begin_q;
		gap_short = CW'(gap_diff) < CW'(min_gap_q);
		fresh     = (window_begin_q == '0) || (CW'(win_diff) >= CW'(window_length_q));
		if (size_s1 > payload_limit_q) begin
			ok = 1'b0;
		end else if (!any_sent_q) begin
			ok = 1'b1;
		end else if (gap_short) begin
			ok = 1'b0;
		end else if (fresh) begin
			ok = 1'b1;
		end else begin
			ok = window_sends_q < burst_limit_q;
		end
		drop_next = ok ? drop_tally_q : drop_tally_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_send_time_q <= '0;
			window_begin_q   <= '0;
			window_sends_q   <= '0;
			any_sent_q       <= 1'b0;
			drop_tally_q     <= '0;
		end else if (advance) begin
			drop_tally_q <= drop_next;
			if (ok) begin
				prev_send_time_q <= time_s1;
				any_sent_q       <= 1'b1;
				if (fresh) begin
					window_begin_q <= time_s1;
					window_sends_q <= 16'd1;
				end else begin
					window_sends_q <= window_sends_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2.send_ok        <= ok;
			rsp_s2.drops_reported <= drop_next;
			rsp_s2.last_send_echo <= ok ? 32'(time_s1) : 32'(prev_send_time_q);
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

endmodule
